>>> design/pgf_pkg.sv
// pgf_pkg: shared types and defaults of the processor grid factorizer
// holds datapath micro-op codes and the command and status structs
// no dependencies
package pgf_pkg;

  localparam int unsigned GridBitsDef = 16;
  localparam int unsigned ProcBitsDef = 16;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_M_XP,
    OP_M_T,
    OP_M_A,
    OP_M_B,
    OP_M_C,
    OP_M_CX,
    OP_M_CY,
    OP_M_R3,
    OP_M_PY,
    OP_M_PZ,
    OP_D_XP,
    OP_D_LO,
    OP_D_SP_R,
    OP_D_NP_R3,
    OP_D_LO3,
    OP_SQ_START,
    OP_SET_S,
    OP_SET_LO_Q,
    OP_SET_LO_1,
    OP_CLAMP,
    OP_UP_INIT,
    OP_R_DEC,
    OP_R_INC,
    OP_CAND,
    OP_KEEP2,
    OP_CLR_F2,
    OP_SET_T,
    OP_SET_A,
    OP_SET_B,
    OP_SET_C,
    OP_SET_LO3_Q,
    OP_SET_LO3_1,
    OP_SUB3,
    OP_KEEP3,
    OP_R3_INC,
    OP_DONE2,
    OP_DONE3,
    OP_FAIL
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } pgf_cmd_t;

  typedef struct packed {
    logic busy;
    logic zero2;
    logic zero3;
    logic rem_zero;
    logic r_ge_lo;
    logic r_le_hi;
    logic r3_le_hi3;
    logic sy_lt_sp;
    logic t_lt_np;
    logic found2;
  } pgf_sts_t;

endpackage

>>> design/pgf_ctrl.sv
// pgf_ctrl: sequencer of the grid factorizer, issues at most one micro-op per cycle
// waits on the shared divider, multiplier and square root unit
// depends on pgf_pkg
module pgf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             mode_i,
  output logic             busy,
  output pgf_pkg::pgf_cmd_t cmd_o,
  input  pgf_pkg::pgf_sts_t sts_i
);
  import pgf_pkg::*;

  typedef enum logic [31:0] {
    S_IDLE    = 32'b1 << 0,
    S_2_CHK   = 32'b1 << 1,
    S_2_DIV   = 32'b1 << 2,
    S_2_SQ    = 32'b1 << 3,
    S_2_S     = 32'b1 << 4,
    S_2_LO    = 32'b1 << 5,
    S_2_LOQ   = 32'b1 << 6,
    S_2_CLAMP = 32'b1 << 7,
    S_DN_TEST = 32'b1 << 8,
    S_DN_CHK  = 32'b1 << 9,
    S_C2_A    = 32'b1 << 10,
    S_C2_B    = 32'b1 << 11,
    S_C2_K    = 32'b1 << 12,
    S_2_UPI   = 32'b1 << 13,
    S_UP_TEST = 32'b1 << 14,
    S_UP_CHK  = 32'b1 << 15,
    S_2_RET   = 32'b1 << 16,
    S_T3_MUL  = 32'b1 << 17,
    S_T3_SET  = 32'b1 << 18,
    S_T3_A    = 32'b1 << 19,
    S_T3_SA   = 32'b1 << 20,
    S_T3_B    = 32'b1 << 21,
    S_T3_SB   = 32'b1 << 22,
    S_T3_C    = 32'b1 << 23,
    S_T3_SC   = 32'b1 << 24,
    S_T3_LO   = 32'b1 << 25,
    S_T3_LOQ  = 32'b1 << 26,
    S_L3_TEST = 32'b1 << 27,
    S_L3_CHK  = 32'b1 << 28,
    S_K3_B    = 32'b1 << 29,
    S_K3_C    = 32'b1 << 30,
    S_K3_K    = 32'b1 << 31
  } state_e;

  state_e state_q, state_d;
  logic   in3_q, in3_d;
  logic   up_q, up_d;
  dp_op_e op;

  assign busy     = (state_q != S_IDLE);
  assign cmd_o.op = op;

  always_comb begin
    state_d = state_q;
    in3_d   = in3_q;
    up_d    = up_q;
    op      = OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op      = OP_LOAD;
          in3_d   = mode_i;
          state_d = mode_i ? S_T3_MUL : S_2_CHK;
        end
      end
      S_2_CHK: begin
        if (sts_i.zero2) begin
          op      = OP_CLR_F2;
          state_d = S_2_RET;
        end else begin
          op      = OP_M_XP;
          state_d = S_2_DIV;
        end
      end
      S_2_DIV: if (!sts_i.busy) begin
        op      = OP_D_XP;
        state_d = S_2_SQ;
      end
      S_2_SQ: if (!sts_i.busy) begin
        op      = OP_SQ_START;
        state_d = S_2_S;
      end
      S_2_S: if (!sts_i.busy) begin
        op      = OP_SET_S;
        state_d = S_2_LO;
      end
      S_2_LO: begin
        if (sts_i.sy_lt_sp) begin
          op      = OP_D_LO;
          state_d = S_2_LOQ;
        end else begin
          op      = OP_SET_LO_1;
          state_d = S_2_CLAMP;
        end
      end
      S_2_LOQ: if (!sts_i.busy) begin
        op      = OP_SET_LO_Q;
        state_d = S_2_CLAMP;
      end
      S_2_CLAMP: begin
        op      = OP_CLAMP;
        up_d    = 1'b0;
        state_d = S_DN_TEST;
      end
      S_DN_TEST: begin
        if (sts_i.r_ge_lo) begin
          op      = OP_D_SP_R;
          state_d = S_DN_CHK;
        end else begin
          op      = OP_UP_INIT;
          up_d    = 1'b1;
          state_d = S_UP_TEST;
        end
      end
      S_DN_CHK: if (!sts_i.busy) begin
        if (sts_i.rem_zero) begin
          op      = OP_CAND;
          state_d = S_C2_A;
        end else begin
          op      = OP_R_DEC;
          state_d = S_DN_TEST;
        end
      end
      S_C2_A: begin
        op      = OP_M_CX;
        state_d = S_C2_B;
      end
      S_C2_B: if (!sts_i.busy) begin
        op      = OP_M_CY;
        state_d = S_C2_K;
      end
      S_C2_K: if (!sts_i.busy) begin
        op      = OP_KEEP2;
        state_d = up_q ? S_2_RET : S_2_UPI;
      end
      S_2_UPI: begin
        op      = OP_UP_INIT;
        up_d    = 1'b1;
        state_d = S_UP_TEST;
      end
      S_UP_TEST: begin
        if (sts_i.r_le_hi) begin
          op      = OP_D_SP_R;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_2_RET;
        end
      end
      S_UP_CHK: if (!sts_i.busy) begin
        if (sts_i.rem_zero) begin
          op      = OP_CAND;
          state_d = S_C2_A;
        end else begin
          op      = OP_R_INC;
          state_d = S_UP_TEST;
        end
      end
      S_2_RET: begin
        if (!in3_q) begin
          op      = OP_DONE2;
          state_d = S_IDLE;
        end else if (sts_i.found2) begin
          op      = OP_M_R3;
          state_d = S_K3_B;
        end else begin
          op      = OP_R3_INC;
          state_d = S_L3_TEST;
        end
      end
      S_T3_MUL: begin
        if (sts_i.zero3) begin
          op      = OP_FAIL;
          state_d = S_IDLE;
        end else begin
          op      = OP_M_T;
          state_d = S_T3_SET;
        end
      end
      S_T3_SET: if (!sts_i.busy) begin
        op      = OP_SET_T;
        state_d = S_T3_A;
      end
      S_T3_A: begin
        op      = OP_M_A;
        state_d = S_T3_SA;
      end
      S_T3_SA: if (!sts_i.busy) begin
        op      = OP_SET_A;
        state_d = S_T3_B;
      end
      S_T3_B: begin
        op      = OP_M_B;
        state_d = S_T3_SB;
      end
      S_T3_SB: if (!sts_i.busy) begin
        op      = OP_SET_B;
        state_d = S_T3_C;
      end
      S_T3_C: begin
        op      = OP_M_C;
        state_d = S_T3_SC;
      end
      S_T3_SC: if (!sts_i.busy) begin
        op      = OP_SET_C;
        state_d = S_T3_LO;
      end
      S_T3_LO: begin
        if (sts_i.t_lt_np) begin
          op      = OP_D_LO3;
          state_d = S_T3_LOQ;
        end else begin
          op      = OP_SET_LO3_1;
          state_d = S_L3_TEST;
        end
      end
      S_T3_LOQ: if (!sts_i.busy) begin
        op      = OP_SET_LO3_Q;
        state_d = S_L3_TEST;
      end
      S_L3_TEST: begin
        if (sts_i.r3_le_hi3) begin
          op      = OP_D_NP_R3;
          state_d = S_L3_CHK;
        end else begin
          op      = OP_DONE3;
          state_d = S_IDLE;
        end
      end
      S_L3_CHK: if (!sts_i.busy) begin
        if (sts_i.rem_zero) begin
          op      = OP_SUB3;
          state_d = S_2_CHK;
        end else begin
          op      = OP_R3_INC;
          state_d = S_L3_TEST;
        end
      end
      S_K3_B: if (!sts_i.busy) begin
        op      = OP_M_PY;
        state_d = S_K3_C;
      end
      S_K3_C: if (!sts_i.busy) begin
        op      = OP_M_PZ;
        state_d = S_K3_K;
      end
      S_K3_K: if (!sts_i.busy) begin
        op      = OP_KEEP3;
        state_d = S_L3_TEST;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      in3_q   <= 1'b0;
      up_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      in3_q   <= in3_d;
      up_q    <= up_d;
    end
  end

endmodule

>>> design/pgf_datapath.sv
// pgf_datapath: operand registers, serial divider, serial multiply-accumulate,
// serial square root and result registers of the grid factorizer
// depends on pgf_pkg
module pgf_datapath #(
  parameter int unsigned GridBits = pgf_pkg::GridBitsDef,
  parameter int unsigned ProcBits = pgf_pkg::ProcBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pgf_pkg::pgf_cmd_t   cmd_i,
  output pgf_pkg::pgf_sts_t   sts_o,
  input  logic [GridBits-1:0] grid_x_i,
  input  logic [GridBits-1:0] grid_y_i,
  input  logic [GridBits-1:0] grid_z_i,
  input  logic [ProcBits-1:0] processes_i,
  output logic                valid_o,
  output logic                status_o,
  output logic [ProcBits-1:0] parts_x_o,
  output logic [ProcBits-1:0] parts_y_o,
  output logic [ProcBits-1:0] parts_z_o
);
  import pgf_pkg::*;

  localparam int unsigned XW  = (GridBits > ProcBits) ? GridBits : ProcBits;
  localparam int unsigned RW  = XW + 1;
  localparam int unsigned QW  = GridBits + ProcBits;
  localparam int unsigned TW  = 2 * GridBits;
  localparam int unsigned DVW = (QW > TW) ? QW : TW;
  localparam int unsigned CW  = XW + TW + 2;
  localparam int unsigned HW  = (QW + 1) / 2;
  localparam int unsigned SQW = 2 * HW;
  localparam int unsigned SH  = DVW - (ProcBits + 1);
  localparam int unsigned DCW = $clog2(DVW + 1);
  localparam int unsigned MCW = $clog2(XW + 1);
  localparam int unsigned SCW = $clog2(HW + 1);

  logic [GridBits-1:0] gx_q, gy_q, gz_q, sx_q, sy_q;
  logic [ProcBits-1:0] np_q, sp_q;
  logic [RW-1:0]       s_q, lo_q, hi_q, r_q, r3_q, hi3_q;
  logic [XW-1:0]       cx_q, cy_q, bx_q, by_q, ox_q, oy_q, oz_q;
  logic [CW-1:0]       best2_q, best3_q;
  logic                found2_q, found3_q;
  logic [TW-1:0]       t_q, a_q, b_q, c_q;
  // divider
  logic [DVW-1:0]      dq_q, dr_q, dd_q;
  logic [DCW-1:0]      dcnt_q;
  // multiply-accumulate
  logic [CW-1:0]       acc_q, my_q;
  logic [XW-1:0]       mx_q;
  logic [MCW-1:0]      mcnt_q;
  // square root
  logic [SQW-1:0]      sv_q;
  logic [HW+1:0]       srem_q;
  logic [HW-1:0]       root_q;
  logic [SCW-1:0]      scnt_q;
  // results
  logic                valid_q, status_q;
  logic [ProcBits-1:0] px_q, py_q, pz_q;

  dp_op_e op;
  assign op = cmd_i.op;

  // unit launch selection
  logic           div_go, div_short, mac_go, mac_clr;
  logic [DVW-1:0] div_x, div_y;
  logic [XW-1:0]  mac_x;
  logic [TW-1:0]  mac_y;
  logic [XW-1:0]  min_gy, min_gz;

  assign min_gy = (XW'(gy_q) < XW'(np_q)) ? XW'(gy_q) : XW'(np_q);
  assign min_gz = (XW'(gz_q) < XW'(np_q)) ? XW'(gz_q) : XW'(np_q);

  always_comb begin
    div_go    = 1'b0;
    div_short = 1'b1;
    div_x     = '0;
    div_y     = '0;
    mac_go    = 1'b0;
    mac_clr   = 1'b0;
    mac_x     = '0;
    mac_y     = '0;
    unique case (op)
      OP_D_XP: begin
        div_go = 1'b1; div_short = 1'b0;
        div_x = DVW'(acc_q[QW-1:0]); div_y = DVW'(sy_q);
      end
      OP_D_LO: begin
        div_go = 1'b1;
        div_x = DVW'(sp_q) + DVW'(sy_q) - DVW'(1); div_y = DVW'(sy_q);
      end
      OP_D_SP_R: begin
        div_go = 1'b1; div_x = DVW'(sp_q); div_y = DVW'(r_q);
      end
      OP_D_NP_R3: begin
        div_go = 1'b1; div_x = DVW'(np_q); div_y = DVW'(r3_q);
      end
      OP_D_LO3: begin
        div_go = 1'b1;
        div_x = DVW'(np_q) + DVW'(t_q) - DVW'(1); div_y = DVW'(t_q);
      end
      OP_M_XP: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = XW'(sp_q); mac_y = TW'(sx_q);
      end
      OP_M_T: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = min_gy; mac_y = TW'(min_gz);
      end
      OP_M_A: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = XW'(gy_q); mac_y = TW'(gz_q);
      end
      OP_M_B: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = XW'(gx_q); mac_y = TW'(gz_q);
      end
      OP_M_C: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = XW'(gx_q); mac_y = TW'(gy_q);
      end
      OP_M_CX: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = cx_q - XW'(1); mac_y = TW'(sy_q);
      end
      OP_M_CY: begin
        mac_go = 1'b1; mac_x = cy_q - XW'(1); mac_y = TW'(sx_q);
      end
      OP_M_R3: begin
        mac_go = 1'b1; mac_clr = 1'b1; mac_x = XW'(r3_q - RW'(1)); mac_y = a_q;
      end
      OP_M_PY: begin
        mac_go = 1'b1; mac_x = bx_q - XW'(1); mac_y = b_q;
      end
      OP_M_PZ: begin
        mac_go = 1'b1; mac_x = by_q - XW'(1); mac_y = c_q;
      end
      default: ;
    endcase
  end

  // one quotient bit per cycle
  logic [DVW:0] dsh, dnr;
  logic         dge;
  assign dsh = {dr_q, dq_q[DVW-1]};
  assign dge = (dsh >= {1'b0, dd_q});
  assign dnr = dge ? (dsh - {1'b0, dd_q}) : dsh;

  // one root bit per cycle
  logic [HW+3:0] st, tr;
  logic          sge;
  assign st  = {srem_q, sv_q[SQW-1 -: 2]};
  assign tr  = (HW+4)'({root_q, 2'b01});
  assign sge = (st >= tr);

  logic [RW-1:0] clamp_lo, clamp_v;
  assign clamp_lo = (s_q < lo_q) ? lo_q : s_q;
  assign clamp_v  = (clamp_lo > hi_q) ? hi_q : clamp_lo;

  logic keep2, keep3;
  assign keep2 = !found2_q || (acc_q < best2_q);
  assign keep3 = !found3_q || (acc_q < best3_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q   <= '0;
      mcnt_q   <= '0;
      scnt_q   <= '0;
      valid_q  <= 1'b0;
      found2_q <= 1'b0;
      found3_q <= 1'b0;
    end else begin
      valid_q <= (op == OP_DONE2) || (op == OP_DONE3) || (op == OP_FAIL);
      if (div_go) begin
        dcnt_q <= div_short ? DCW'(ProcBits + 1) : DCW'(DVW);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - DCW'(1);
      end
      if (mac_go) begin
        mcnt_q <= MCW'(XW);
      end else if (mcnt_q != '0) begin
        mcnt_q <= mcnt_q - MCW'(1);
      end
      if (op == OP_SQ_START) begin
        scnt_q <= SCW'(HW);
      end else if (scnt_q != '0) begin
        scnt_q <= scnt_q - SCW'(1);
      end
      unique case (op)
        OP_LOAD: begin
          found2_q <= 1'b0;
          found3_q <= 1'b0;
        end
        OP_CLAMP, OP_CLR_F2: found2_q <= 1'b0;
        OP_KEEP2: if (keep2) found2_q <= 1'b1;
        OP_KEEP3: if (keep3) found3_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (div_go) begin
      dq_q <= div_short ? DVW'(div_x << SH) : div_x;
      dr_q <= '0;
      dd_q <= div_y;
    end else if (dcnt_q != '0) begin
      dq_q <= {dq_q[DVW-2:0], dge};
      dr_q <= dnr[DVW-1:0];
    end
    if (mac_go) begin
      if (mac_clr) acc_q <= '0;
      mx_q <= mac_x;
      my_q <= CW'(mac_y);
    end else if (mcnt_q != '0) begin
      if (mx_q[0]) acc_q <= acc_q + my_q;
      mx_q <= mx_q >> 1;
      my_q <= my_q << 1;
    end
    if (op == OP_SQ_START) begin
      sv_q   <= SQW'(dq_q[QW-1:0]);
      srem_q <= '0;
      root_q <= '0;
    end else if (scnt_q != '0) begin
      sv_q   <= sv_q << 2;
      srem_q <= sge ? (HW+2)'(st - tr) : (HW+2)'(st);
      root_q <= {root_q[HW-2:0], sge};
    end
    unique case (op)
      OP_LOAD: begin
        gx_q <= grid_x_i;
        gy_q <= grid_y_i;
        gz_q <= grid_z_i;
        np_q <= processes_i;
        sx_q <= grid_x_i;
        sy_q <= grid_y_i;
        sp_q <= processes_i;
      end
      OP_SET_S: begin
        s_q  <= RW'(root_q);
        hi_q <= (RW'(sx_q) < RW'(sp_q)) ? RW'(sx_q) : RW'(sp_q);
      end
      OP_SET_LO_Q: lo_q <= RW'(dq_q);
      OP_SET_LO_1: lo_q <= RW'(1);
      OP_CLAMP: begin
        s_q <= clamp_v;
        r_q <= clamp_v;
      end
      OP_UP_INIT: r_q <= s_q + RW'(1);
      OP_R_DEC:   r_q <= r_q - RW'(1);
      OP_R_INC:   r_q <= r_q + RW'(1);
      OP_CAND: begin
        cx_q <= XW'(r_q);
        cy_q <= XW'(dq_q);
      end
      OP_KEEP2: if (keep2) begin
        bx_q    <= cx_q;
        by_q    <= cy_q;
        best2_q <= acc_q;
      end
      OP_SET_T: begin
        t_q   <= acc_q[TW-1:0];
        hi3_q <= (RW'(gx_q) < RW'(np_q)) ? RW'(gx_q) : RW'(np_q);
      end
      OP_SET_A:     a_q  <= acc_q[TW-1:0];
      OP_SET_B:     b_q  <= acc_q[TW-1:0];
      OP_SET_C:     c_q  <= acc_q[TW-1:0];
      OP_SET_LO3_Q: r3_q <= RW'(dq_q);
      OP_SET_LO3_1: r3_q <= RW'(1);
      OP_SUB3: begin
        sx_q <= gy_q;
        sy_q <= gz_q;
        sp_q <= ProcBits'(dq_q);
      end
      OP_KEEP3: begin
        if (keep3) begin
          ox_q    <= XW'(r3_q);
          oy_q    <= bx_q;
          oz_q    <= by_q;
          best3_q <= acc_q;
        end
        r3_q <= r3_q + RW'(1);
      end
      OP_R3_INC: r3_q <= r3_q + RW'(1);
      OP_DONE2: begin
        status_q <= !found2_q;
        px_q     <= found2_q ? ProcBits'(bx_q) : '0;
        py_q     <= found2_q ? ProcBits'(by_q) : '0;
        pz_q     <= found2_q ? ProcBits'(1) : '0;
      end
      OP_DONE3: begin
        status_q <= !found3_q;
        px_q     <= found3_q ? ProcBits'(ox_q) : '0;
        py_q     <= found3_q ? ProcBits'(oy_q) : '0;
        pz_q     <= found3_q ? ProcBits'(oz_q) : '0;
      end
      OP_FAIL: begin
        status_q <= 1'b1;
        px_q     <= '0;
        py_q     <= '0;
        pz_q     <= '0;
      end
      default: ;
    endcase
  end

  assign sts_o.busy      = (dcnt_q != '0) || (mcnt_q != '0) || (scnt_q != '0);
  assign sts_o.zero2     = (sx_q == '0) || (sy_q == '0) || (sp_q == '0);
  assign sts_o.zero3     = (gx_q == '0) || (gy_q == '0) || (gz_q == '0) || (np_q == '0);
  assign sts_o.rem_zero  = (dr_q == '0);
  assign sts_o.r_ge_lo   = (r_q >= lo_q);
  assign sts_o.r_le_hi   = (r_q <= hi_q);
  assign sts_o.r3_le_hi3 = (r3_q <= hi3_q);
  assign sts_o.sy_lt_sp  = (XW'(sy_q) < XW'(sp_q));
  assign sts_o.t_lt_np   = (DVW'(t_q) < DVW'(np_q));
  assign sts_o.found2    = found2_q;

  assign valid_o   = valid_q;
  assign status_o  = status_q;
  assign parts_x_o = px_q;
  assign parts_y_o = py_q;
  assign parts_z_o = pz_q;

endmodule

>>> design/processor_grid_factorizer.sv
// processor_grid_factorizer: top level, splits a process count over a 2D or 3D grid
// joins the pgf_ctrl sequencer and the pgf_datapath; depends on pgf_pkg
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+---------------------------
//  request  | op_i grid_x_i grid_y_i grid_z_i processes_i      | taken when start & !busy
//  result   | status_o parts_x_o parts_y_o parts_z_o           | valid_o strobe, one cycle
//
// one request at a time; busy stays high until the cycle the result strobes
// 2D: setup, then one division of the process count per candidate divisor scanned,
//   and a further multiply-accumulate and compare per divisor hit
// 3D: setup, then one division per candidate along the first axis plus one full 2D
//   split for every divisor found
// the divider is serial, one quotient bit per cycle, and shared by all tests
// reset clears the sequencer and the strobe; results cannot be held off by the receiver
module processor_grid_factorizer #(
  parameter int unsigned GRID_BITS = pgf_pkg::GridBitsDef,
  parameter int unsigned PROC_BITS = pgf_pkg::ProcBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op_i,
  input  logic [GRID_BITS-1:0] grid_x_i,
  input  logic [GRID_BITS-1:0] grid_y_i,
  input  logic [GRID_BITS-1:0] grid_z_i,
  input  logic [PROC_BITS-1:0] processes_i,
  output logic                 valid_o,
  output logic                 status_o,
  output logic [PROC_BITS-1:0] parts_x_o,
  output logic [PROC_BITS-1:0] parts_y_o,
  output logic [PROC_BITS-1:0] parts_z_o
);
  import pgf_pkg::*;

  pgf_cmd_t cmd;
  pgf_sts_t sts;

  pgf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (op_i),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  pgf_datapath #(
    .GridBits (GRID_BITS),
    .ProcBits (PROC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .grid_x_i    (grid_x_i),
    .grid_y_i    (grid_y_i),
    .grid_z_i    (grid_z_i),
    .processes_i (processes_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .parts_x_o   (parts_x_o),
    .parts_y_o   (parts_y_o),
    .parts_z_o   (parts_z_o)
  );

endmodule

>>> design/pgf_checker.sv
// pgf_checker: port-level assertions for processor_grid_factorizer
// bound to the top level below; depends on nothing else
module pgf_checker #(
  parameter int unsigned GRID_BITS = 16,
  parameter int unsigned PROC_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 valid_o,
  input logic                 status_o,
  input logic [PROC_BITS-1:0] parts_x_o,
  input logic [PROC_BITS-1:0] parts_y_o,
  input logic [PROC_BITS-1:0] parts_z_o
);

  // a taken request makes the block busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after request");

  // the result strobes only once the block is free again
  a_idle_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |->
      (parts_x_o == '0 && parts_y_o == '0 && parts_z_o == '0))
    else $error("failed split with nonzero parts");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !status_o) |->
      (parts_x_o != '0 && parts_y_o != '0 && parts_z_o != '0))
    else $error("found split with a zero part");

endmodule

bind processor_grid_factorizer pgf_checker #(
  .GRID_BITS (GRID_BITS),
  .PROC_BITS (PROC_BITS)
) u_pgf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .valid_o   (valid_o),
  .status_o  (status_o),
  .parts_x_o (parts_x_o),
  .parts_y_o (parts_y_o),
  .parts_z_o (parts_z_o)
);
